[sv/sst_pkg.sv]
`default_nettype none
package sst_pkg;

  localparam int unsigned MAX_UNIQUE_DEFAULT = 1000000;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned NUM_W = 20;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_BROKEN = 2'd2;
  localparam logic [1:0] KIND_TOOBIG = 2'd3;

  // One request from the parser to the output side: an optional character
  // and an optional closing result (string end, string broken or count too large).
  typedef struct packed {
    logic             has_char;
    logic [15:0]      cp;
    logic             has_term;
    logic [1:0]       term_kind;
    logic [NUM_W-1:0] num;
  } job_t;

  localparam int unsigned JOB_W = $bits(job_t);

endpackage
`default_nettype wire

[sv/sst_fifo.sv]
`default_nettype none
module sst_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/sst_front.sv]
`default_nettype none
module sst_front #(
  parameter int unsigned MAX_UNIQUE_STRINGS = sst_pkg::MAX_UNIQUE_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        segment_start,
  input  wire logic        end_of_data,
  output logic             job_valid,
  output sst_pkg::job_t    job
);
  import sst_pkg::*;

  localparam logic [3:0] PH_HDR    = 4'd0;
  localparam logic [3:0] PH_CNT0   = 4'd1;
  localparam logic [3:0] PH_CNT1   = 4'd2;
  localparam logic [3:0] PH_FLAGS  = 4'd3;
  localparam logic [3:0] PH_RICH0  = 4'd4;
  localparam logic [3:0] PH_RICH1  = 4'd5;
  localparam logic [3:0] PH_EXT0   = 4'd6;
  localparam logic [3:0] PH_EXT1   = 4'd7;
  localparam logic [3:0] PH_EXT2   = 4'd8;
  localparam logic [3:0] PH_EXT3   = 4'd9;
  localparam logic [3:0] PH_CHAR   = 4'd10;
  localparam logic [3:0] PH_CHARHI = 4'd11;
  localparam logic [3:0] PH_SKIP   = 4'd12;

  logic [3:0]       phase, phase_next;
  logic [2:0]       hdr_idx, hdr_idx_next;
  logic [NUM_W-1:0] unique_total, unique_total_next;
  logic [NUM_W-1:0] strings_done, strings_done_next;
  logic [15:0]      chars_left, chars_left_next;
  logic             wide_chars, wide_chars_next;
  logic             has_rich, has_rich_next;
  logic             has_ext, has_ext_next;
  logic [15:0]      rich_count, rich_count_next;
  logic [31:0]      ext_count, ext_count_next;
  logic [32:0]      skip_left, skip_left_next;
  logic [7:0]       low_hold, low_hold_next;
  logic             halted, halted_next;

  logic             do_after;
  logic             do_end;
  logic             do_begin;
  logic [32:0]      skip_calc;
  logic [31:0]      count_acc;

  always_comb begin
    phase_next        = phase;
    hdr_idx_next      = hdr_idx;
    unique_total_next = unique_total;
    strings_done_next = strings_done;
    chars_left_next   = chars_left;
    wide_chars_next   = wide_chars;
    has_rich_next     = has_rich;
    has_ext_next      = has_ext;
    rich_count_next   = rich_count;
    ext_count_next    = ext_count;
    skip_left_next    = skip_left;
    low_hold_next     = low_hold;
    halted_next       = halted;
    do_after          = 1'b0;
    do_end            = 1'b0;
    do_begin          = 1'b0;
    skip_calc         = '0;
    count_acc         = skip_left[31:0];
    job               = '0;
    job.num           = strings_done;

    if (!halted) begin
      unique case (phase)
        PH_HDR: begin
          if (segment_start && hdr_idx != 3'd0) begin
            halted_next = 1'b1;
          end else begin
            if (hdr_idx[2]) begin
              count_acc[8*hdr_idx[1:0] +: 8] = data_byte;
            end
            skip_left_next = {1'b0, count_acc};
            hdr_idx_next   = hdr_idx + 3'd1;
            if (hdr_idx == 3'd7) begin
              if (count_acc > 32'(MAX_UNIQUE_STRINGS)) begin
                job.has_term  = 1'b1;
                job.term_kind = KIND_TOOBIG;
                job.num       = '0;
                halted_next   = 1'b1;
              end else begin
                unique_total_next = count_acc[NUM_W-1:0];
                skip_left_next    = '0;
                phase_next        = PH_CNT0;
                if (count_acc == '0) begin
                  halted_next = 1'b1;
                end
              end
            end
          end
        end
        PH_CNT0: begin
          chars_left_next = {8'h00, data_byte};
          phase_next      = PH_CNT1;
        end
        PH_CNT1: begin
          chars_left_next[15:8] = data_byte;
          phase_next            = PH_FLAGS;
        end
        PH_FLAGS: begin
          wide_chars_next = data_byte[0];
          has_rich_next   = data_byte[3];
          has_ext_next    = data_byte[2];
          rich_count_next = '0;
          ext_count_next  = '0;
          if (data_byte[3]) begin
            phase_next = PH_RICH0;
          end else if (data_byte[2]) begin
            phase_next = PH_EXT0;
          end else begin
            do_begin = 1'b1;
          end
        end
        PH_RICH0: begin
          rich_count_next = {8'h00, data_byte};
          phase_next      = PH_RICH1;
        end
        PH_RICH1: begin
          rich_count_next[15:8] = data_byte;
          if (has_ext) begin
            phase_next = PH_EXT0;
          end else begin
            do_begin = 1'b1;
          end
        end
        PH_EXT0, PH_EXT1, PH_EXT2, PH_EXT3: begin
          ext_count_next[8*(2'(phase - PH_EXT0)) +: 8] = data_byte;
          if (phase == PH_EXT3) begin
            do_begin = 1'b1;
          end else begin
            phase_next = phase + 4'd1;
          end
        end
        PH_CHAR: begin
          if (segment_start) begin
            wide_chars_next = data_byte[0];
          end else if (wide_chars) begin
            low_hold_next = data_byte;
            phase_next    = PH_CHARHI;
          end else begin
            job.has_char    = 1'b1;
            job.cp          = {8'h00, data_byte};
            chars_left_next = chars_left - 16'd1;
            if (chars_left_next == '0) begin
              do_after = 1'b1;
            end else begin
              phase_next = PH_CHAR;
            end
          end
        end
        PH_CHARHI: begin
          if (segment_start) begin
            job.has_term  = 1'b1;
            job.term_kind = KIND_BROKEN;
            halted_next   = 1'b1;
          end else begin
            job.has_char    = 1'b1;
            job.cp          = {data_byte, low_hold};
            chars_left_next = chars_left - 16'd1;
            if (chars_left_next == '0) begin
              do_after = 1'b1;
            end else begin
              phase_next = PH_CHAR;
            end
          end
        end
        PH_SKIP: begin
          skip_left_next = skip_left - 33'd1;
          if (skip_left_next == '0) begin
            do_end = 1'b1;
          end
        end
        default: begin
          halted_next = 1'b1;
        end
      endcase

      if (do_begin) begin
        if (chars_left != '0) begin
          phase_next = PH_CHAR;
        end else begin
          do_after = 1'b1;
        end
      end

      if (do_after) begin
        skip_calc = {15'd0, rich_count_next, 2'b00} + {1'b0, ext_count_next};
        if (skip_calc != '0) begin
          skip_left_next = skip_calc;
          phase_next     = PH_SKIP;
        end else begin
          do_end = 1'b1;
        end
      end

      if (do_end) begin
        job.has_term      = 1'b1;
        job.term_kind     = KIND_END;
        strings_done_next = strings_done + 1'b1;
        if (strings_done_next == unique_total_next) begin
          halted_next = 1'b1;
        end
        phase_next = PH_CNT0;
      end

      if (end_of_data && !halted_next && phase_next != PH_HDR && phase_next != PH_CNT0) begin
        job.has_term  = 1'b1;
        job.term_kind = KIND_BROKEN;
      end
    end
  end

  assign job_valid = job.has_char || job.has_term;

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_data)) begin
      phase        <= PH_HDR;
      hdr_idx      <= '0;
      unique_total <= '0;
      strings_done <= '0;
      chars_left   <= '0;
      wide_chars   <= 1'b0;
      has_rich     <= 1'b0;
      has_ext      <= 1'b0;
      rich_count   <= '0;
      ext_count    <= '0;
      skip_left    <= '0;
      low_hold     <= '0;
      halted       <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      hdr_idx      <= hdr_idx_next;
      unique_total <= unique_total_next;
      strings_done <= strings_done_next;
      chars_left   <= chars_left_next;
      wide_chars   <= wide_chars_next;
      has_rich     <= has_rich_next;
      has_ext      <= has_ext_next;
      rich_count   <= rich_count_next;
      ext_count    <= ext_count_next;
      skip_left    <= skip_left_next;
      low_hold     <= low_hold_next;
      halted       <= halted_next;
    end
  end

endmodule
`default_nettype wire

[sv/sst_back.sv]
`default_nettype none
module sst_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  job_avail,
  input  wire sst_pkg::job_t         job_head,
  output logic                       job_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_kind,
  output logic [7:0]                 out_byte,
  output logic [sst_pkg::NUM_W-1:0]  out_num,
  output logic                       out_last
);
  import sst_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;

  logic [1:0] nchar;
  logic [7:0] utf [3];
  logic [2:0] total;
  logic       is_last;
  logic       load_out;
  logic [1:0] item_kind;
  logic [7:0] item_byte;

  always_comb begin
    utf[0] = cur.cp[7:0];
    utf[1] = 8'h00;
    utf[2] = 8'h00;
    nchar  = 2'd1;
    if (cur.cp[15:7] == '0) begin
      nchar  = 2'd1;
      utf[0] = {1'b0, cur.cp[6:0]};
    end else if (cur.cp[15:11] == '0) begin
      nchar  = 2'd2;
      utf[0] = {3'b110, cur.cp[10:6]};
      utf[1] = {2'b10, cur.cp[5:0]};
    end else begin
      nchar  = 2'd3;
      utf[0] = {4'b1110, cur.cp[15:12]};
      utf[1] = {2'b10, cur.cp[11:6]};
      utf[2] = {2'b10, cur.cp[5:0]};
    end

    total = (cur.has_char ? {1'b0, nchar} : 3'd0) + {2'b00, cur.has_term};
    is_last = ({1'b0, idx} == total - 3'd1);

    if (cur.has_char && idx < nchar) begin
      item_kind = KIND_BYTE;
      item_byte = utf[idx];
    end else begin
      item_kind = cur.term_kind;
      item_byte = 8'h00;
    end
  end

  assign load_out = cur_valid && (!out_valid || out_ready);
  assign job_pop  = job_avail && (!cur_valid || (load_out && is_last));

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job_head;
    end
    if (load_out) begin
      out_kind <= item_kind;
      out_byte <= item_byte;
      out_num  <= cur.num;
      out_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (job_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (load_out) begin
        if (is_last) begin
          cur_valid <= 1'b0;
          idx       <= '0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[sv/shared_string_table_decoder_top.sv]
// Shared-string table decoder. Table body bytes enter on the s_ stream, one per
// cycle, with s_tuser marking the first byte of each record body and s_tlast the
// final byte of the table. A parser takes each byte and in the same cycle posts a
// request (one character and/or a closing mark) into a 4-entry queue; the output
// side turns each request into 1 to 4 results (UTF-8 bytes, then string end,
// string broken or count too large) and sends one result per cycle from an output
// register while m_tready is high. Input runs at one byte per cycle as long as the
// queue has room, so the sustained rate is set by the output side, which sends the
// results of a request one after another, at most 4 of them.
// A string reported as broken is to be discarded by the consumer; after it, and
// after all counted strings, bytes are taken and dropped until s_tlast.
`default_nettype none
module shared_string_table_decoder_top #(
  parameter int unsigned MAX_UNIQUE_STRINGS = sst_pkg::MAX_UNIQUE_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] segment_start
  input  wire logic        s_tlast,   // end_of_data
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [7:0] out_byte, [27:8] string_number, rest zero
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast    // last_of_run
);
  import sst_pkg::*;

  logic             accept;
  logic             front_job_valid;
  job_t             front_job;
  logic             q_full;
  logic             q_not_empty;
  logic             q_pop;
  logic [JOB_W-1:0] q_head;
  logic [7:0]       out_byte;
  logic [NUM_W-1:0] out_num;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  sst_front #(
    .MAX_UNIQUE_STRINGS(MAX_UNIQUE_STRINGS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_tdata),
    .segment_start(s_tuser),
    .end_of_data  (s_tlast),
    .job_valid    (front_job_valid),
    .job          (front_job)
  );

  sst_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && front_job_valid),
    .wr_data  (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .rd_data  (q_head)
  );

  sst_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_avail(q_not_empty),
    .job_head (job_t'(q_head)),
    .job_pop  (q_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_kind (m_tuser),
    .out_byte (out_byte),
    .out_num  (out_num),
    .out_last (m_tlast)
  );

  assign m_tdata = {4'h0, out_num, out_byte};

endmodule
`default_nettype wire

[sv/sst_checker.sv]
`default_nettype none
module sst_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);
  import sst_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn before it was taken");

  a_mark_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_BYTE |-> m_tdata[7:0] == 8'h00 && m_tlast)
    else $error("closing mark carries a byte or is not last of its run");

  a_toobig_number: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_TOOBIG |-> m_tdata[27:8] == '0)
    else $error("count error carries a string number");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tdata[27:8] == $past(m_tdata[27:8]))
    else $error("results of one input byte split or renumbered");

endmodule

bind shared_string_table_decoder_top sst_checker u_sst_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
`default_nettype wire
